>>> sv/jseu8_pkg.sv
// ----------------------------------------------------------------------------
// jseu8_pkg
// shared types, constants and helpers of the json string escaper
// ----------------------------------------------------------------------------
package jseu8_pkg;

    localparam longint MAX_VALUE_BYTES = 64'd65536;
    localparam longint OFFSET_LIMIT_L  =
        (MAX_VALUE_BYTES - 1 < 64'd65535) ? MAX_VALUE_BYTES - 1 : 64'd65535;
    localparam logic [15:0] OFFSET_LIMIT = OFFSET_LIMIT_L[15:0];

    localparam int MAX_RESULTS = 8;
    localparam int QDEPTH      = 4;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_VALUE = 2'd1;
    localparam logic [1:0] STATUS_NAME  = 2'd2;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_MAX = 8'h1F;

    // utf-8 lead and continuation bounds
    localparam logic [7:0] ASCII_END = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_SUR = 8'hED;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] CONT_E0_LO = 8'hA0;
    localparam logic [7:0] CONT_ED_HI = 8'h9F;
    localparam logic [7:0] CONT_F0_LO = 8'h90;
    localparam logic [7:0] CONT_F4_HI = 8'h8F;

    // one item's worth of results, as queued between front and back
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [3:0]                  count;
        logic                        err;
        logic                        name;
        logic                        last;
        logic [15:0]                 offset;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        logic full;
        t_cmd cmd;
    } t_qhead;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        r = (v < 4'd10) ? (8'h30 + {4'b0, v}) : (8'h37 + {4'b0, v});
        return r;
    endfunction

endpackage

>>> sv/jseu8_if.sv
// ----------------------------------------------------------------------------
// jseu8 channel interfaces
// valid/ready channels for input bytes and output results
// ----------------------------------------------------------------------------
interface jseu8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       first_of_value;
    logic       last_of_value;
    logic       check_text;
    logic       add_quotes;
    logic       is_name;

    modport source (
        output valid, data_byte, byte_present, first_of_value, last_of_value,
               check_text, add_quotes, is_name,
        input  ready
    );
    modport sink (
        input  valid, data_byte, byte_present, first_of_value, last_of_value,
               check_text, add_quotes, is_name,
        output ready
    );
endinterface

interface jseu8_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        value_done;
    logic [1:0]  status;
    logic [15:0] error_offset;

    modport source (
        output valid, out_byte, run_last, value_done, status, error_offset,
        input  ready
    );
    modport sink (
        input  valid, out_byte, run_last, value_done, status, error_offset,
        output ready
    );
endinterface

>>> sv/jseu8_front.sv
// ----------------------------------------------------------------------------
// jseu8_front
// accepts input beats, tracks utf-8 state and builds the result list per beat
// ----------------------------------------------------------------------------
module jseu8_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    jseu8_in_if.sink           i_in,
    input  logic               i_full,
    output jseu8_pkg::t_push   o_push
);

    logic [2:0][7:0] r_held, n_held;
    logic [1:0]      r_held_cnt, n_held_cnt;
    logic [1:0]      r_need, n_need;
    logic [15:0]     r_offset, n_offset;
    logic [15:0]     r_seq, n_seq;
    logic            r_drop, n_drop;

    logic                                  accept;
    logic [jseu8_pkg::MAX_RESULTS-1:0][7:0] v_bytes;
    logic [3:0]                            v_n;
    logic                                  v_err;
    logic [15:0]                           v_pos;
    logic [15:0]                           v_err_off;
    logic [7:0]                            v_lo;
    logic [7:0]                            v_hi;
    logic [7:0]                            c;

    assign c        = i_in.data_byte;
    assign i_in.ready = !i_full;
    assign accept   = i_in.valid && !i_full;

    always_comb begin
        v_bytes    = '0;
        v_n        = 4'd0;
        v_err      = 1'b0;
        v_lo       = jseu8_pkg::CONT_LO;
        v_hi       = jseu8_pkg::CONT_HI;
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_need     = r_need;
        n_offset   = r_offset;
        n_seq      = r_seq;
        n_drop     = r_drop;

        if (i_in.first_of_value) begin
            n_held     = '0;
            n_held_cnt = 2'd0;
            n_need     = 2'd0;
            n_offset   = 16'd0;
            n_seq      = 16'd0;
            n_drop     = 1'b0;
            if (i_in.add_quotes) begin
                v_bytes[v_n[2:0]] = jseu8_pkg::CH_QUOTE;
                v_n = v_n + 4'd1;
            end
        end
        v_pos = n_offset;

        if (!n_drop && i_in.byte_present) begin
            if (n_offset < jseu8_pkg::OFFSET_LIMIT) begin
                n_offset = n_offset + 16'd1;
            end
            if (!i_in.check_text) begin
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < n_held_cnt) begin
                        v_bytes[v_n[2:0]] = n_held[k];
                        v_n = v_n + 4'd1;
                    end
                end
                n_held     = '0;
                n_held_cnt = 2'd0;
                n_need     = 2'd0;
                v_bytes[v_n[2:0]] = c;
                v_n = v_n + 4'd1;
            end else if (n_held_cnt == 2'd0) begin
                priority if (c == jseu8_pkg::CH_QUOTE || c == jseu8_pkg::CH_BSLASH) begin
                    v_bytes[v_n[2:0]] = jseu8_pkg::CH_BSLASH;
                    v_n = v_n + 4'd1;
                    v_bytes[v_n[2:0]] = c;
                    v_n = v_n + 4'd1;
                end else if (c <= jseu8_pkg::CTL_MAX) begin
                    v_bytes[v_n[2:0]] = jseu8_pkg::CH_BSLASH;
                    v_n = v_n + 4'd1;
                    if (c == jseu8_pkg::CTL_BS) begin
                        v_bytes[v_n[2:0]] = jseu8_pkg::CH_B;
                        v_n = v_n + 4'd1;
                    end else if (c == jseu8_pkg::CTL_TAB) begin
                        v_bytes[v_n[2:0]] = jseu8_pkg::CH_T;
                        v_n = v_n + 4'd1;
                    end else if (c == jseu8_pkg::CTL_LF) begin
                        v_bytes[v_n[2:0]] = jseu8_pkg::CH_N;
                        v_n = v_n + 4'd1;
                    end else if (c == jseu8_pkg::CTL_FF) begin
                        v_bytes[v_n[2:0]] = jseu8_pkg::CH_F;
                        v_n = v_n + 4'd1;
                    end else if (c == jseu8_pkg::CTL_CR) begin
                        v_bytes[v_n[2:0]] = jseu8_pkg::CH_R;
                        v_n = v_n + 4'd1;
                    end else begin
                        v_bytes[v_n[2:0]] = jseu8_pkg::CH_U;
                        v_n = v_n + 4'd1;
                        v_bytes[v_n[2:0]] = jseu8_pkg::CH_ZERO;
                        v_n = v_n + 4'd1;
                        v_bytes[v_n[2:0]] = jseu8_pkg::CH_ZERO;
                        v_n = v_n + 4'd1;
                        v_bytes[v_n[2:0]] = jseu8_pkg::hex_digit(c[7:4]);
                        v_n = v_n + 4'd1;
                        v_bytes[v_n[2:0]] = jseu8_pkg::hex_digit(c[3:0]);
                        v_n = v_n + 4'd1;
                    end
                end else if (c < jseu8_pkg::ASCII_END) begin
                    v_bytes[v_n[2:0]] = c;
                    v_n = v_n + 4'd1;
                end else begin
                    n_seq = v_pos;
                    priority if (c >= jseu8_pkg::LEAD2_LO && c <= jseu8_pkg::LEAD2_HI) begin
                        n_need = 2'd1;
                    end else if (c >= jseu8_pkg::LEAD3_LO && c <= jseu8_pkg::LEAD3_HI) begin
                        n_need = 2'd2;
                    end else if (c >= jseu8_pkg::LEAD4_LO && c <= jseu8_pkg::LEAD4_HI) begin
                        n_need = 2'd3;
                    end else begin
                        v_err = 1'b1;
                    end
                    if (!v_err) begin
                        n_held     = {16'd0, c};
                        n_held_cnt = 2'd1;
                    end
                end
            end else begin
                // second byte of some leads has a narrower range
                if (n_held_cnt == 2'd1) begin
                    if (n_held[0] == jseu8_pkg::LEAD3_LO) begin
                        v_lo = jseu8_pkg::CONT_E0_LO;
                    end else if (n_held[0] == jseu8_pkg::LEAD3_SUR) begin
                        v_hi = jseu8_pkg::CONT_ED_HI;
                    end else if (n_held[0] == jseu8_pkg::LEAD4_LO) begin
                        v_lo = jseu8_pkg::CONT_F0_LO;
                    end else if (n_held[0] == jseu8_pkg::LEAD4_HI) begin
                        v_hi = jseu8_pkg::CONT_F4_HI;
                    end
                end
                if (c < v_lo || c > v_hi) begin
                    v_err = 1'b1;
                end else if (n_need <= 2'd1) begin
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < n_held_cnt) begin
                            v_bytes[v_n[2:0]] = n_held[k];
                            v_n = v_n + 4'd1;
                        end
                    end
                    n_held     = '0;
                    n_held_cnt = 2'd0;
                    n_need     = 2'd0;
                    v_bytes[v_n[2:0]] = c;
                    v_n = v_n + 4'd1;
                end else begin
                    n_held[n_held_cnt] = c;
                    n_held_cnt = n_held_cnt + 2'd1;
                    n_need     = n_need - 2'd1;
                end
            end
        end

        if (!n_drop && !v_err && i_in.last_of_value) begin
            if (n_held_cnt != 2'd0) begin
                if (i_in.check_text) begin
                    v_err = 1'b1;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < n_held_cnt) begin
                            v_bytes[v_n[2:0]] = n_held[k];
                            v_n = v_n + 4'd1;
                        end
                    end
                    n_held     = '0;
                    n_held_cnt = 2'd0;
                    n_need     = 2'd0;
                end
            end
            if (!v_err && i_in.add_quotes) begin
                v_bytes[v_n[2:0]] = jseu8_pkg::CH_QUOTE;
                v_n = v_n + 4'd1;
            end
        end

        v_err_off = n_seq;
        if (v_err) begin
            // error result slot carries no byte
            v_bytes[v_n[2:0]] = 8'h00;
            v_n        = v_n + 4'd1;
            n_held     = '0;
            n_held_cnt = 2'd0;
            n_need     = 2'd0;
            n_drop     = 1'b1;
        end

        if (i_in.last_of_value) begin
            n_held     = '0;
            n_held_cnt = 2'd0;
            n_need     = 2'd0;
            n_offset   = 16'd0;
            n_seq      = 16'd0;
            n_drop     = 1'b0;
        end

        o_push.valid      = accept && (v_n != 4'd0);
        o_push.cmd.bytes  = v_bytes;
        o_push.cmd.count  = v_n;
        o_push.cmd.err    = v_err;
        o_push.cmd.name   = i_in.is_name;
        o_push.cmd.last   = i_in.last_of_value;
        o_push.cmd.offset = v_err_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_held_cnt <= 2'd0;
            r_need     <= 2'd0;
            r_offset   <= 16'd0;
            r_seq      <= 16'd0;
            r_drop     <= 1'b0;
        end else if (accept) begin
            r_held     <= n_held;
            r_held_cnt <= n_held_cnt;
            r_need     <= n_need;
            r_offset   <= n_offset;
            r_seq      <= n_seq;
            r_drop     <= n_drop;
        end
    end

endmodule

>>> sv/jseu8_queue.sv
// ----------------------------------------------------------------------------
// jseu8_queue
// short fifo of per-beat result lists between front and back
// ----------------------------------------------------------------------------
module jseu8_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jseu8_pkg::t_push  i_push,
    input  logic              i_pop,
    output jseu8_pkg::t_qhead o_head
);

    localparam int PTR_W = $clog2(jseu8_pkg::QDEPTH);

    jseu8_pkg::t_cmd r_mem [jseu8_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_head.valid = (r_cnt != '0);
    assign o_head.full  = (r_cnt == (PTR_W+1)'(jseu8_pkg::QDEPTH));
    assign o_head.cmd   = r_mem[r_rd];

    assign do_push = i_push.valid && !o_head.full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> sv/jseu8_back.sv
// ----------------------------------------------------------------------------
// jseu8_back
// walks the head result list; one result beat per cycle unless stalled
// ----------------------------------------------------------------------------
module jseu8_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jseu8_pkg::t_qhead i_head,
    output logic              o_pop,
    jseu8_out_if.source       o_out
);

    logic [2:0]  r_idx, n_idx;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_run_last;
    logic        r_done;
    logic [1:0]  r_status;
    logic [15:0] r_offset;

    logic        load;
    logic        is_end;
    logic        is_err;

    assign load   = i_head.valid && (!r_valid || o_out.ready);
    assign is_end = ({1'b0, r_idx} + 4'd1) == i_head.cmd.count;
    assign is_err = i_head.cmd.err && is_end;
    assign o_pop  = load && is_end;
    assign n_idx  = is_end ? 3'd0 : r_idx + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= is_err ? 8'h00 : i_head.cmd.bytes[r_idx];
            r_run_last <= is_end;
            r_done     <= is_err || (is_end && i_head.cmd.last);
            r_status   <= !is_err ? jseu8_pkg::STATUS_OK :
                          i_head.cmd.name ? jseu8_pkg::STATUS_NAME :
                          jseu8_pkg::STATUS_VALUE;
            r_offset   <= is_err ? i_head.cmd.offset : 16'd0;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_byte;
    assign o_out.run_last     = r_run_last;
    assign o_out.value_done   = r_done;
    assign o_out.status       = r_status;
    assign o_out.error_offset = r_offset;

endmodule

>>> sv/json_string_escaper_utf8_check_unit.sv
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_check_unit
// json string escaping with utf-8 validation, one input byte per beat
// ----------------------------------------------------------------------------
// i_in_ch carries one byte of a text value per beat with its value framing
// and mode bits; o_out_ch carries the resulting text bytes, or a single error
// beat (status nonzero, offset of the bad sequence) that ends the value.
// The front stage updates the utf-8 state and builds the full result list of
// a beat in the accept cycle, and writes it into a four-entry queue.
// The back stage walks the list one result per cycle, while the receiver is
// ready, into an output register. A result passes through the queue entry
// and then the output register before it is valid at the output.
// Throughput: one input beat per cycle while each beat gives at most one
// result and the receiver is ready; a beat with several results holds the
// back stage through them all (up to eight for a quoted \u00NN escape), and
// input waits for a free queue entry; a beat with no result is not queued.
// Reset clears the utf-8 state, the queue and the output register.
// When the receiver stalls, the output beat holds, the queue fills, and
// i_in_ch.ready drops once all four entries are in use.
// ----------------------------------------------------------------------------
module json_string_escaper_utf8_check_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jseu8_in_if.sink      i_in_ch,
    jseu8_out_if.source   o_out_ch
);

    jseu8_pkg::t_push  push;
    jseu8_pkg::t_qhead head;
    logic              pop;

    jseu8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_ch),
        .i_full  (head.full),
        .o_push  (push)
    );

    jseu8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head)
    );

    jseu8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out_ch)
    );

    // error beat always closes the run and the value
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.status != jseu8_pkg::STATUS_OK)
            |-> (o_out_ch.run_last && o_out_ch.value_done))
        else $error("error result without run_last/value_done");

    a_done_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.value_done) |-> o_out_ch.run_last)
        else $error("value_done on a non-final result");

    // nothing can appear at the output without a queued list
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!head.valid && !o_out_ch.valid) |=> !o_out_ch.valid)
        else $error("output beat with empty queue");

endmodule

>>> dv/jseu8_escape_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jseu8_escape_checker
// watches both channels of the escaper, predicts the text beats of every
// accepted input beat and compares them in order with the output beats
// ----------------------------------------------------------------------------
module jseu8_escape_checker
    import jseu8_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    jseu8_in_if   i_in_ch,
    jseu8_out_if  i_out_ch,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_live_beats
);

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        run_last;
        logic        value_done;
        logic [1:0]  status;
        logic [15:0] error_offset;
    } t_text_beat;

    // escaper state as the block should hold it
    logic [23:0] seq_bytes;
    logic [1:0]  seq_len;
    logic [1:0]  seq_need;
    logic [15:0] text_pos;
    logic [15:0] seq_pos;
    logic        drop_rest;

    t_text_beat  beat_list[$];
    t_text_beat  text_expected[$];
    int          fails;
    int          live;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? CH_ZERO + {4'd0, v} : 8'h41 + {4'd0, v} - 8'd10;
    endfunction

    task automatic put_text(input logic [7:0] b);
        t_text_beat r;
        r = '0;
        r.out_byte = b;
        r.status = STATUS_OK;
        beat_list.insert(beat_list.size(), r);
    endtask

    task automatic drop_seq();
        seq_bytes = '0;
        seq_len = '0;
        seq_need = '0;
    endtask

    task automatic clear_value();
        drop_seq();
        text_pos = '0;
        seq_pos = '0;
        drop_rest = 1'b0;
    endtask

    task automatic release_seq();
        int k;
        for (k = 0; k < int'(seq_len); k++) put_text(seq_bytes[8*k +: 8]);
        drop_seq();
    endtask

    task automatic escape_checked(input logic [7:0] c, input logic [15:0] pos,
                                  output logic bad);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [1:0] need;
        bad = 1'b0;
        lo = CONT_LO;
        hi = CONT_HI;
        need = 2'd0;
        if (seq_len == 2'd0) begin
            if (c == CH_QUOTE || c == CH_BSLASH) begin
                put_text(CH_BSLASH);
                put_text(c);
            end else if (c <= CTL_MAX) begin
                put_text(CH_BSLASH);
                case (c)
                    CTL_BS:  put_text(CH_B);
                    CTL_TAB: put_text(CH_T);
                    CTL_LF:  put_text(CH_N);
                    CTL_FF:  put_text(CH_F);
                    CTL_CR:  put_text(CH_R);
                    default: begin
                        put_text(CH_U);
                        put_text(CH_ZERO);
                        put_text(CH_ZERO);
                        put_text(hex_char(c[7:4]));
                        put_text(hex_char(c[3:0]));
                    end
                endcase
            end else if (c < ASCII_END) begin
                put_text(c);
            end else begin
                if (c >= LEAD2_LO && c <= LEAD2_HI) need = 2'd1;
                else if (c >= LEAD3_LO && c <= LEAD3_HI) need = 2'd2;
                else if (c >= LEAD4_LO && c <= LEAD4_HI) need = 2'd3;
                seq_pos = pos;
                if (need == 2'd0) begin
                    bad = 1'b1;
                end else begin
                    seq_bytes = {16'd0, c};
                    seq_len = 2'd1;
                    seq_need = need;
                end
            end
        end else begin
            // second byte of a sequence has a narrower range after some leads
            if (seq_len == 2'd1) begin
                case (seq_bytes[7:0])
                    LEAD3_LO:  lo = CONT_E0_LO;
                    LEAD3_SUR: hi = CONT_ED_HI;
                    LEAD4_LO:  lo = CONT_F0_LO;
                    LEAD4_HI:  hi = CONT_F4_HI;
                    default: ;
                endcase
            end
            if (c < lo || c > hi) begin
                bad = 1'b1;
            end else if (seq_need <= 2'd1) begin
                release_seq();
                put_text(c);
            end else begin
                seq_bytes[8*int'(seq_len) +: 8] = c;
                seq_len = seq_len + 2'd1;
                seq_need = seq_need - 2'd1;
            end
        end
    endtask

    task automatic predict_beat(input logic [7:0] c, input logic pres,
                                input logic opens, input logic closes,
                                input logic checked, input logic quoted,
                                input logic name);
        logic        bad;
        logic [15:0] pos;
        t_text_beat  r;
        int          n;
        bad = 1'b0;
        beat_list.delete();
        if (opens) begin
            clear_value();
            if (quoted) put_text(CH_QUOTE);
        end
        if (!drop_rest && pres) begin
            pos = text_pos;
            if (text_pos < OFFSET_LIMIT) text_pos = text_pos + 16'd1;
            if (!checked) begin
                release_seq();
                put_text(c);
            end else begin
                escape_checked(c, pos, bad);
            end
        end
        if (!drop_rest && !bad && closes) begin
            if (seq_len != 2'd0) begin
                if (checked) bad = 1'b1;
                else release_seq();
            end
            if (!bad && quoted) put_text(CH_QUOTE);
        end
        if (bad) begin
            r = '0;
            r.run_last = 1'b1;
            r.value_done = 1'b1;
            r.status = name ? STATUS_NAME : STATUS_VALUE;
            r.error_offset = seq_pos;
            beat_list.insert(beat_list.size(), r);
            drop_seq();
            drop_rest = 1'b1;
        end else if (beat_list.size() > 0) begin
            n = beat_list.size() - 1;
            r = beat_list[n];
            r.run_last = 1'b1;
            if (closes) r.value_done = 1'b1;
            beat_list[n] = r;
        end
        if (closes) clear_value();
        foreach (beat_list[k]) text_expected.insert(text_expected.size(), beat_list[k]);
    endtask

    task automatic note_fail(input string what, input t_text_beat want,
                             input t_text_beat got);
        if (fails < 10) begin
            $write("%t %s: expected byte %h last %b done %b status %0d off %0d, ",
                   $time, what, want.out_byte, want.run_last, want.value_done,
                   want.status, want.error_offset);
            $display("got byte %h last %b done %b status %0d off %0d",
                     got.out_byte, got.run_last, got.value_done, got.status,
                     got.error_offset);
        end
        fails++;
    endtask

    always @(posedge i_clk) begin : watch
        t_text_beat got;
        t_text_beat want;
        if (!i_rst_n) begin
            clear_value();
            text_expected.delete();
            fails = 0;
            live = 0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                // beats swallowed after an error do not count as live traffic
                if (i_in_ch.first_of_value ||
                    (!drop_rest && (i_in_ch.byte_present || i_in_ch.last_of_value)))
                    live++;
                predict_beat(i_in_ch.data_byte, i_in_ch.byte_present,
                             i_in_ch.first_of_value, i_in_ch.last_of_value,
                             i_in_ch.check_text, i_in_ch.add_quotes, i_in_ch.is_name);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.out_byte = i_out_ch.out_byte;
                got.run_last = i_out_ch.run_last;
                got.value_done = i_out_ch.value_done;
                got.status = i_out_ch.status;
                got.error_offset = i_out_ch.error_offset;
                if (text_expected.size() == 0) begin
                    note_fail("unexpected beat", '0, got);
                end else begin
                    want = text_expected.pop_front();
                    // the byte field carries nothing on an error beat
                    if (want.status != got.status || want.run_last != got.run_last ||
                        want.value_done != got.value_done ||
                        want.error_offset != got.error_offset ||
                        (want.status == STATUS_OK && want.out_byte != got.out_byte))
                        note_fail("mismatch", want, got);
                end
            end
        end
        o_pending <= text_expected.size();
        o_fail_count <= fails;
        o_live_beats <= live;
    end

endmodule

>>> dv/tb_json_string_escaper_utf8_check_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_escaper_utf8_check_unit
// drives directed and random text values into the escaper under changing
// sender gaps and receiver stalls; the checker predicts and compares beats
// ----------------------------------------------------------------------------
module tb_json_string_escaper_utf8_check_unit;
    import jseu8_pkg::*;

    localparam int RANDOM_BEATS = 300;
    localparam int LIMIT        = 600000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       first_of_value;
        logic       last_of_value;
        logic       check_text;
        logic       add_quotes;
        logic       is_name;
    } t_text_item;

    logic i_clk;
    logic i_rst_n;

    jseu8_in_if  in_ch();
    jseu8_out_if out_ch();

    int fail_count;
    int pending;
    int live_beats;
    int taken_beats = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    t_text_item stim_q[$];

    json_string_escaper_utf8_check_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    jseu8_escape_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_live_beats (live_beats)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) taken_beats <= taken_beats + 1;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_json_string_escaper_utf8_check_unit: FAIL");
        $finish;
    end

    task automatic queue_item(input logic [7:0] d, input logic pres,
                              input logic opens, input logic closes,
                              input logic checked, input logic quoted,
                              input logic name);
        t_text_item it;
        it.data_byte = d;
        it.byte_present = pres;
        it.first_of_value = opens;
        it.last_of_value = closes;
        it.check_text = checked;
        it.add_quotes = quoted;
        it.is_name = name;
        stim_q.insert(stim_q.size(), it);
    endtask

    task automatic drive_beat(input t_text_item it);
        int target;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        target = taken_beats + 1;
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= it.data_byte;
        in_ch.byte_present <= it.byte_present;
        in_ch.first_of_value <= it.first_of_value;
        in_ch.last_of_value <= it.last_of_value;
        in_ch.check_text <= it.check_text;
        in_ch.add_quotes <= it.add_quotes;
        in_ch.is_name <= it.is_name;
        do @(negedge i_clk); while (taken_beats < target);
    endtask

    task automatic send_queued();
        while (stim_q.size() > 0) drive_beat(stim_q.pop_front());
    endtask

    // sender holds off until the output side has delivered everything
    task automatic drain_output();
        while (pending != 0) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    function automatic logic [7:0] second_byte(input logic [7:0] lead);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_LO;
        hi = CONT_HI;
        case (lead)
            LEAD3_LO:  lo = CONT_E0_LO;
            LEAD3_SUR: hi = CONT_ED_HI;
            LEAD4_LO:  lo = CONT_F0_LO;
            LEAD4_HI:  hi = CONT_F4_HI;
            default: ;
        endcase
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return 8'($urandom_range(hi, lo));
        endcase
    endfunction

    // one text value: mostly well formed utf-8 with escapes, some broken
    task automatic build_value();
        logic [7:0] text[$];
        logic [7:0] lead;
        logic       checked;
        logic       quoted;
        logic       name;
        logic       opens;
        int         tokens;
        int         ending;
        int         k;
        text.delete();
        tokens = $urandom_range(8);
        for (k = 0; k < tokens; k++) begin
            case ($urandom_range(99)) inside
                [0:29]: text.insert(text.size(), 8'($urandom_range(8'h7E, 8'h20)));
                [30:44]: begin
                    case ($urandom_range(2))
                        0:       text.insert(text.size(), CH_QUOTE);
                        1:       text.insert(text.size(), CH_BSLASH);
                        default: text.insert(text.size(), 8'($urandom_range(CTL_MAX)));
                    endcase
                end
                [45:59]: begin
                    lead = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
                    text.insert(text.size(), lead);
                    text.insert(text.size(), second_byte(lead));
                end
                [60:77]: begin
                    lead = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
                    text.insert(text.size(), lead);
                    text.insert(text.size(), second_byte(lead));
                    text.insert(text.size(), 8'($urandom_range(CONT_HI, CONT_LO)));
                end
                [78:92]: begin
                    lead = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
                    text.insert(text.size(), lead);
                    text.insert(text.size(), second_byte(lead));
                    text.insert(text.size(), 8'($urandom_range(CONT_HI, CONT_LO)));
                    text.insert(text.size(), 8'($urandom_range(CONT_HI, CONT_LO)));
                end
                default: text.insert(text.size(), 8'($urandom_range(8'h7F)));
            endcase
        end
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(2))
                0: begin
                    if (text.size() > 0) text[$urandom_range(text.size() - 1)] =
                        8'($urandom_range(255));
                    else text.insert(text.size(), 8'($urandom_range(255)));
                end
                1: text.insert($urandom_range(text.size()),
                               8'($urandom_range(8'hFF, 8'h80)));
                default: text.insert(text.size(),
                                     8'($urandom_range(LEAD4_HI, LEAD2_LO)));
            endcase
        end
        checked = ($urandom_range(99) < 85);
        quoted = 1'($urandom_range(1));
        name = 1'($urandom_range(1));
        opens = ($urandom_range(99) >= 4);
        ending = $urandom_range(99);   // below 6: abandoned, below 18: end marker
        if (text.size() == 0) begin
            queue_item(8'($urandom_range(255)), 1'b0, opens, ending >= 6,
                       checked, quoted, name);
            return;
        end
        for (k = 0; k < text.size(); k++) begin
            if (k > 0 && $urandom_range(99) < 3)
                queue_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0,
                           checked, quoted, name);
            queue_item(text[k], 1'b1, opens && k == 0,
                       ending >= 18 && k == text.size() - 1,
                       ($urandom_range(99) < 4) ? !checked : checked, quoted, name);
        end
        if (ending >= 6 && ending < 18)
            queue_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1,
                       checked, quoted, name);
    endtask

    initial begin : stimulus
        int         base;
        int         phase;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.byte_present = 1'b0;
        in_ch.first_of_value = 1'b0;
        in_ch.last_of_value = 1'b0;
        in_ch.check_text = 1'b0;
        in_ch.add_quotes = 1'b0;
        in_ch.is_name = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty quoted value, then a lone nul giving the longest escape
        queue_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        // every short escape, a \u00NN escape and the top four byte code point
        queue_item(CH_QUOTE,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CTL_BS,    1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CTL_TAB,   1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CTL_LF,    1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CTL_FF,    1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CTL_CR,    1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CTL_MAX,   1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(LEAD4_HI,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CONT_F4_HI, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CONT_HI,   1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(CONT_HI,   1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        // surrogate in a name: error after the quote, rest dropped, silent end
        queue_item(LEAD3_SUR, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        queue_item(CONT_E0_LO, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        queue_item(8'h41,     1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        queue_item(8'h42,     1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        // raw bytes flush a held sequence, also at the end of the value
        queue_item(LEAD4_LO,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(8'hFF,     1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_item(LEAD3_LO,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_item(8'h00,     1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        // truncated sequence in checked mode
        queue_item(8'hC3,     1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_item(8'h00,     1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        // bad lead on the opening beat: quote then error
        queue_item(8'hF5,     1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        send_queued();

        base = live_beats;
        for (phase = 0; phase < 4; phase++) begin
            drain_output();
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            while (live_beats < base + (phase + 1) * RANDOM_BEATS / 4) begin
                build_value();
                send_queued();
            end
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_json_string_escaper_utf8_check_unit: PASS");
        else
            $display("tb_json_string_escaper_utf8_check_unit: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/jseu8_pkg.sv
sv/jseu8_if.sv
sv/jseu8_front.sv
sv/jseu8_queue.sv
sv/jseu8_back.sv
sv/json_string_escaper_utf8_check_unit.sv
dv/jseu8_escape_checker.sv
dv/tb_json_string_escaper_utf8_check_unit.sv
